>>> src/postfix_stack_evaluator_core_defines.svh
// Assertion macros used by the evaluator core.
`ifndef POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PSE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("postfix evaluator assertion failed");
`define PSE_ASSERT_NORST(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("postfix evaluator assertion failed");
`else
`define PSE_ASSERT(label, prop)
`define PSE_ASSERT_NORST(label, prop)
`endif

`endif

>>> src/pse_pkg.sv
package pse_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int DATA_W          = 8;
	localparam int FLAG_W          = 3;

	localparam logic [DATA_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [DATA_W-1:0] CH_NINE   = 8'h39;
	localparam logic [DATA_W-1:0] CH_EMPTY  = 8'h24;
	localparam logic [DATA_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [DATA_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [DATA_W-1:0] CH_TIMES  = 8'h2A;
	localparam logic [DATA_W-1:0] CH_DIVIDE = 8'h2F;

	localparam int FLAG_DIV   = 0;
	localparam int FLAG_UNDER = 1;
	localparam int FLAG_OVER  = 2;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> src/pse_ram.sv
module pse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr_a,
	output logic [WIDTH-1:0] rd_data_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

>>> src/pse_div.sv
module pse_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pse_pkg::div_req_t  req,
	output pse_pkg::div_rsp_t  rsp
);

	import pse_pkg::*;

	localparam int CNT_W = $clog2(DATA_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0] num_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W-1:0] rem_q;
	logic              neg_q;

	logic [DATA_W:0]   partial;
	logic [DATA_W:0]   diff;
	logic              q_bit;
	logic [DATA_W-1:0] rem_next;
	logic [DATA_W-1:0] num_next;
	logic [DATA_W-1:0] num_mag;
	logic [DATA_W-1:0] den_mag;

	always_comb begin
		num_mag  = req.dividend[DATA_W-1] ? (~req.dividend + DATA_W'(1)) : req.dividend;
		den_mag  = req.divisor[DATA_W-1] ? (~req.divisor + DATA_W'(1)) : req.divisor;
		partial  = {rem_q, num_q[DATA_W-1]};
		diff     = partial - {1'b0, den_q};
		q_bit    = !diff[DATA_W];
		rem_next = q_bit ? diff[DATA_W-1:0] : partial[DATA_W-1:0];
		num_next = {num_q[DATA_W-2:0], q_bit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= num_mag;
			den_q <= den_mag;
			rem_q <= '0;
			neg_q <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
		end else if (busy_q) begin
			num_q <= num_next;
			rem_q <= rem_next;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (~num_q + DATA_W'(1)) : num_q;

endmodule

>>> src/postfix_stack_evaluator_core.sv
// Postfix expression evaluator.
// Input stream: one character per transfer on s_tdata, s_tlast marks the last
// character of an expression. Digits push 0..9; + - * / pop two and push the
// 8-bit result; other codes pop two and push nothing.
// Output stream: one transfer per expression on m_tdata (final value, 36 when
// the stack is empty) with m_tuser flags divide-by-zero, underflow, overflow.
// Each character is accepted in ST_IDLE, which reads the top two stack entries
// through the two-read-port stack RAM, then in ST_EXEC updates the stack;
// s_tready stays low until it is done. A '/' with a nonzero divisor waits in
// ST_DIV for the bit-serial divider (one quotient bit per cycle). A last
// character that pops without pushing and leaves values needs one extra RAM
// read in ST_TOP to fetch the new top. m_tvalid and the result are registered.
// Reset empties the stack and clears the flags at once; no clearing pass.
// The result waits in an output register; new characters are still taken
// while it waits, and only a further last character stalls until it leaves.
module postfix_stack_evaluator_core #(
	parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pse_pkg::DATA_W-1:0]        s_tdata,   // [7:0] symbol
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic signed [pse_pkg::DATA_W-1:0] m_tdata,   // [7:0] value
	output logic [pse_pkg::FLAG_W-1:0]        m_tuser    // [0] divided_by_zero,
	                                                     // [1] underflowed, [2] overflowed
);

	import pse_pkg::*;

	`include "postfix_stack_evaluator_core_defines.svh"

	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_TOP  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [SPW-1:0]    sp_q;
	logic [FLAG_W-1:0] flags_q;
	logic [DATA_W-1:0] sym_q;
	logic              last_q;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic [FLAG_W-1:0] m_tuser_q;

	logic [DATA_W-1:0] rd_a;
	logic [DATA_W-1:0] rd_b;
	logic              rd_en;
	logic [AW-1:0]     rd_addr_a;
	logic [AW-1:0]     rd_addr_b;
	logic              wr_en;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic              is_digit;
	logic              is_op;
	logic              has1;
	logic              has2;
	logic              full;
	logic [DATA_W-1:0] right;
	logic [DATA_W-1:0] left;
	logic [DATA_W-1:0] arith;
	logic              need_div;
	logic              push_en;
	logic [AW-1:0]     push_addr;
	logic [DATA_W-1:0] push_data;
	logic [SPW-1:0]    sp_pop;
	logic [SPW-1:0]    sp_next;
	logic [DATA_W-1:0] top_val;
	logic [FLAG_W-1:0] flag_set;
	logic [FLAG_W-1:0] flags_next;
	logic              go_top;
	logic              final_empty;
	logic [DATA_W-1:0] out_value;
	logic [FLAG_W-1:0] out_flags;

	logic accept;
	logic out_free;
	logic commit;
	logic top_emit;
	logic emit;

	always_comb begin
		is_digit = sym_q inside {[CH_ZERO:CH_NINE]};
		is_op    = sym_q inside {CH_PLUS, CH_MINUS, CH_TIMES, CH_DIVIDE};
		has1     = sp_q != '0;
		has2     = sp_q > SPW'(1);
		full     = sp_q == SPW'(STACK_DEPTH);
		right    = has1 ? rd_a : CH_EMPTY;
		left     = has2 ? rd_b : CH_EMPTY;
		need_div = (sym_q == CH_DIVIDE) && (right != '0);

		case (sym_q)
			CH_PLUS: begin
				arith = left + right;
			end
			CH_MINUS: begin
				arith = left - right;
			end
			CH_TIMES: begin
				arith = DATA_W'(left * right);
			end
			CH_DIVIDE: begin
				arith = (right == '0) ? '0 : div_rsp.quotient;
			end
			default: begin
				arith = '0;
			end
		endcase

		flag_set  = '0;
		push_en   = 1'b0;
		push_addr = AW'(sp_q);
		push_data = arith;
		sp_pop    = has2 ? (sp_q - SPW'(2)) : '0;
		sp_next   = sp_q;
		top_val   = rd_a;

		if (is_digit) begin
			if (full) begin
				flag_set[FLAG_OVER] = 1'b1;
			end else begin
				push_en   = 1'b1;
				push_data = sym_q - CH_ZERO;
				sp_next   = sp_q + SPW'(1);
				top_val   = sym_q - CH_ZERO;
			end
		end else begin
			flag_set[FLAG_UNDER] = !has2;
			if (is_op) begin
				push_en   = 1'b1;
				push_addr = AW'(sp_pop);
				sp_next   = sp_pop + SPW'(1);
				top_val   = arith;
				flag_set[FLAG_DIV] = (sym_q == CH_DIVIDE) && (right == '0);
			end else begin
				sp_next = sp_pop;
			end
		end

		flags_next  = flags_q | flag_set;
		go_top      = !is_digit && !is_op && last_q && (sp_pop != '0);
		final_empty = sp_next == '0;
		out_value   = final_empty ? CH_EMPTY : top_val;
		out_flags   = flags_next;
		out_flags[FLAG_UNDER] = flags_next[FLAG_UNDER] | final_empty;
	end

	assign accept   = s_tvalid && (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign commit   = ((state_q == ST_EXEC) && !need_div && !go_top && (!last_q || out_free))
		|| ((state_q == ST_DIV) && div_rsp.done && (!last_q || out_free));
	assign top_emit = (state_q == ST_TOP) && out_free;
	assign emit     = (commit && last_q) || top_emit;

	assign rd_en     = accept || ((state_q == ST_EXEC) && go_top);
	assign rd_addr_a = (state_q == ST_IDLE) ? AW'(sp_q - SPW'(1)) : AW'(sp_pop - SPW'(1));
	assign rd_addr_b = AW'(sp_q - SPW'(2));
	assign wr_en     = commit && push_en;

	assign div_req.start    = (state_q == ST_EXEC) && need_div;
	assign div_req.dividend = left;
	assign div_req.divisor  = right;

	pse_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (push_addr),
		.wr_data  (push_data),
		.rd_en    (rd_en),
		.rd_addr_a(rd_addr_a),
		.rd_data_a(rd_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_b(rd_b)
	);

	pse_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (need_div) begin
						state_q <= ST_DIV;
					end else if (go_top) begin
						state_q <= ST_TOP;
					end else if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TOP: begin
					if (top_emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			flags_q <= '0;
		end else if (commit) begin
			sp_q    <= last_q ? '0 : sp_next;
			flags_q <= last_q ? '0 : flags_next;
		end else if ((state_q == ST_EXEC) && go_top) begin
			sp_q    <= sp_pop;
			flags_q <= flags_next;
		end else if (top_emit) begin
			sp_q    <= '0;
			flags_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q  <= s_tdata;
			last_q <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= top_emit ? rd_a : out_value;
			m_tuser_q <= top_emit ? flags_q : out_flags;
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = $signed(m_tdata_q);
	assign m_tuser  = m_tuser_q;

	`PSE_ASSERT(a_sp_bound, sp_q <= SPW'(STACK_DEPTH))
	`PSE_ASSERT(a_last_clears, (commit && last_q) |=> (sp_q == '0) && (flags_q == '0))
	`PSE_ASSERT(a_div_wait, div_req.start |=> (state_q == ST_DIV) && !div_rsp.done)
	`PSE_ASSERT(a_wr_rd_excl, wr_en |-> !rd_en)

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import pse_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     divided_by_zero;
		logic                     underflowed;
		logic                     overflowed;
	} expression_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [DATA_W-1:0]        s_tdata = '0;
	logic                     s_tlast = 1'b0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic signed [DATA_W-1:0] m_tdata;
	logic [FLAG_W-1:0]        m_tuser;

	logic [DATA_W-1:0]  operand_stack [STACK_DEPTH_DEF];
	int                 operand_count = 0;
	logic               saw_div_zero = 1'b0;
	logic               saw_underflow = 1'b0;
	logic               saw_overflow = 1'b0;
	expression_result_t pending_expression_results [$];
	logic [DATA_W-1:0]  expr_chars [$];

	int error_count = 0;
	int symbols_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	postfix_stack_evaluator_core #(
		.STACK_DEPTH(STACK_DEPTH_DEF)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #10 clk = ~clk;

	function automatic int pop_operand();
		if (operand_count == 0) begin
			saw_underflow = 1'b1;
			return int'(CH_EMPTY);
		end
		operand_count--;
		return int'($signed(operand_stack[operand_count]));
	endfunction

	function automatic void push_operand(int v);
		if (operand_count >= STACK_DEPTH_DEF) begin
			saw_overflow = 1'b1;
		end else begin
			operand_stack[operand_count] = v[DATA_W-1:0];
			operand_count++;
		end
	endfunction

	function automatic void evaluate_symbol(logic [DATA_W-1:0] sym, logic is_last);
		int                 rhs;
		int                 lhs;
		int                 top;
		expression_result_t res;
		if (sym >= CH_ZERO && sym <= CH_NINE) begin
			push_operand(int'(sym - CH_ZERO));
		end else begin
			rhs = pop_operand();
			lhs = pop_operand();
			case (sym)
				CH_PLUS:   push_operand(lhs + rhs);
				CH_MINUS:  push_operand(lhs - rhs);
				CH_TIMES:  push_operand(lhs * rhs);
				CH_DIVIDE: begin
					if (rhs == 0) begin
						saw_div_zero = 1'b1;
						push_operand(0);
					end else begin
						push_operand(lhs / rhs);
					end
				end
				default: ;
			endcase
		end
		if (is_last) begin
			top = pop_operand();
			res.value = top[DATA_W-1:0];
			res.divided_by_zero = saw_div_zero;
			res.underflowed = saw_underflow;
			res.overflowed = saw_overflow;
			pending_expression_results.push_back(res);
			operand_count = 0;
			saw_div_zero = 1'b0;
			saw_underflow = 1'b0;
			saw_overflow = 1'b0;
		end
	endfunction

	function automatic logic [DATA_W-1:0] random_operator();
		case ($urandom_range(3))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_TIMES;
			default: return CH_DIVIDE;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] random_digit();
		return CH_ZERO + DATA_W'($urandom_range(9));
	endfunction

	function automatic void build_wellformed(int operands);
		int depth;
		int placed;
		depth = 0;
		placed = 0;
		expr_chars.delete();
		while (placed < operands || depth > 1) begin
			if (placed < operands && (depth < 2 || $urandom_range(1) == 0)) begin
				expr_chars.push_back(random_digit());
				depth++;
				placed++;
			end else begin
				expr_chars.push_back(random_operator());
				depth--;
			end
		end
	endfunction

	task automatic send_symbol(input logic [DATA_W-1:0] sym, input logic is_last);
		s_tvalid <= 1'b1;
		s_tdata <= sym;
		s_tlast <= is_last;
		do @(posedge clk); while (!s_tready);
		evaluate_symbol(sym, is_last);
		symbols_sent++;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_expression();
		foreach (expr_chars[i])
			send_symbol(expr_chars[i], i == expr_chars.size() - 1);
	endtask

	task automatic test_basic_ops();
		expr_chars = '{CH_ZERO + 8'd3, CH_ZERO + 8'd4, CH_PLUS};
		send_expression();
		expr_chars = '{CH_NINE};
		send_expression();
		expr_chars = '{CH_ZERO};
		send_expression();
	endtask

	task automatic test_min_quotient();
		// build -128 from -8 * 16, then divide by -1
		expr_chars = '{CH_ZERO, CH_ZERO + 8'd8, CH_MINUS,
			CH_ZERO + 8'd4, CH_ZERO + 8'd4, CH_TIMES, CH_TIMES,
			CH_ZERO, CH_ZERO + 8'd1, CH_MINUS, CH_DIVIDE};
		send_expression();
	endtask

	task automatic test_divide_by_zero();
		expr_chars = '{CH_ZERO + 8'd7, CH_ZERO, CH_DIVIDE};
		send_expression();
	endtask

	task automatic test_empty_stack();
		expr_chars = '{8'h00};
		send_expression();
		expr_chars = '{CH_NINE, 8'hFF};
		send_expression();
		expr_chars = '{CH_PLUS};
		send_expression();
	endtask

	task automatic test_stack_overflow();
		build_wellformed(0);
		repeat (STACK_DEPTH_DEF) expr_chars.push_back(random_digit());
		send_expression();
		expr_chars.delete();
		repeat (STACK_DEPTH_DEF + 2) expr_chars.push_back(random_digit());
		expr_chars.push_back(random_operator());
		send_expression();
	endtask

	task automatic test_back_pressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left <= HOLD_CYCLES;
		repeat (12) begin
			build_wellformed($urandom_range(1, 4));
			send_expression();
		end
	endtask

	task automatic test_random(input int n_symbols, input int idle_pct, input int stall_pct);
		int first;
		int kind;
		int pos;
		first = symbols_sent;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (symbols_sent - first < n_symbols) begin
			kind = $urandom_range(99);
			if (kind < 85) begin
				build_wellformed(($urandom_range(9) == 0) ? $urandom_range(10, 30)
					: $urandom_range(1, 6));
				if (kind >= 70) begin
					pos = $urandom_range(expr_chars.size() - 1);
					case ($urandom_range(2))
						0: expr_chars.push_back(random_operator());
						1: if (expr_chars.size() > 1) expr_chars.delete(expr_chars.size() - 1);
						default: expr_chars[pos] = DATA_W'($urandom_range(255));
					endcase
				end
			end else begin
				expr_chars.delete();
				repeat ($urandom_range(1, 8)) expr_chars.push_back(DATA_W'($urandom_range(255)));
			end
			send_expression();
		end
	endtask

	always @(posedge clk) begin : check_results
		expression_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_expression_results.size() == 0) begin
				$error("unexpected result transfer: value %0d flags %b", m_tdata, m_tuser);
				error_count++;
			end else begin
				want = pending_expression_results.pop_front();
				if (m_tdata !== want.value) begin
					$error("value: expected %0d, actual %0d", want.value, m_tdata);
					error_count++;
				end
				if (m_tuser[FLAG_DIV] !== want.divided_by_zero) begin
					$error("divided_by_zero: expected %b, actual %b",
						want.divided_by_zero, m_tuser[FLAG_DIV]);
					error_count++;
				end
				if (m_tuser[FLAG_UNDER] !== want.underflowed) begin
					$error("underflowed: expected %b, actual %b",
						want.underflowed, m_tuser[FLAG_UNDER]);
					error_count++;
				end
				if (m_tuser[FLAG_OVER] !== want.overflowed) begin
					$error("overflowed: expected %b, actual %b",
						want.overflowed, m_tuser[FLAG_OVER]);
					error_count++;
				end
			end
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_min_quotient();
		test_divide_by_zero();
		test_empty_stack();
		test_stack_overflow();
		test_back_pressure();
		test_random(150, 0, 0);
		test_random(150, 56, 0);
		test_random(150, 0, 56);
		test_random(150, 6, 6);
		s_tvalid <= 1'b0;
		while (pending_expression_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
